// File: rtl/fpd_pkg.sv
// Shared types and constants for the foveated patch downsampler.
// Depends on nothing; every other file of the block imports it.
package fpd_pkg;

    localparam int PIXEL_BITS = 8;
    localparam int WIN_SIZE   = 16;
    localparam int COL_BITS   = $clog2(WIN_SIZE);
    localparam int OUT_BITS   = 8;
    localparam int IDX_BITS   = 7;
    localparam int SUM_BITS   = PIXEL_BITS + 2;

    localparam logic [IDX_BITS-1:0] VEC_LAST = IDX_BITS'(111);

    // Centre columns of the middle row pairs, and the column whose average
    // is followed by the upper centre pixels.
    localparam logic [COL_BITS-1:0] CENTER_LO   = COL_BITS'(4);
    localparam logic [COL_BITS-1:0] CENTER_HI   = COL_BITS'(12);
    localparam logic [COL_BITS-1:0] BURST_COL   = COL_BITS'(3);
    localparam logic [COL_BITS-1:0] EDGE_COL_A  = COL_BITS'(1);
    localparam logic [COL_BITS-1:0] EDGE_COL_B  = COL_BITS'(13);
    localparam logic [COL_BITS-1:0] EDGE_COL_C  = COL_BITS'(15);
    localparam logic [COL_BITS-1:0] LAST_COL    = COL_BITS'(WIN_SIZE - 1);

    localparam int BURST_LEN  = 8;
    localparam int BURST_BITS = $clog2(BURST_LEN);
    localparam logic [BURST_BITS-1:0] BURST_END = BURST_BITS'(BURST_LEN - 1);

    // Row pairs 2..5 are the middle pairs.
    localparam logic [COL_BITS-2:0] PAIR_MID_LO = (COL_BITS-1)'(2);
    localparam logic [COL_BITS-2:0] PAIR_MID_HI = (COL_BITS-1)'(5);

    typedef logic [PIXEL_BITS-1:0] pix_t;
    typedef logic [COL_BITS-1:0]   col_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_RD_B,
        S_AVG,
        S_BRD,
        S_BLD,
        S_PASS
    } state_t;

    typedef struct packed {
        logic wr_en;
        col_t wr_addr;
        pix_t wr_data;
        logic rd_en;
        col_t rd_addr;
    } fpd_mem_req_t;

    typedef struct packed {
        logic load;
        logic clear;
        pix_t value;
        logic last;
    } fpd_emit_t;

endpackage

// File: rtl/fpd_line_store.sv
// Line store holding the even row of the current row pair.
// Synchronous memory with one write and one registered read port; uses fpd_pkg.
module fpd_line_store (
    input  logic                 clk,
    input  fpd_pkg::fpd_mem_req_t req,
    output fpd_pkg::pix_t        rd_data
);
    import fpd_pkg::*;

    pix_t mem [WIN_SIZE];
    pix_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            mem[req.wr_addr] <= req.wr_data;
        end
        if (req.rd_en)
        begin
            rd_data_reg <= mem[req.rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: rtl/fpd_out_stage.sv
// Output register of the downsampler with the vector position counter.
// Uses fpd_pkg for the load request struct and index constants.
module fpd_out_stage (
    input  logic                clk,
    input  logic                rst_n,
    input  fpd_pkg::fpd_emit_t  emit,
    output logic                free,
    output logic                out_valid,
    input  logic                out_stall,
    output logic [7:0]          out_value,
    output logic [6:0]          out_index,
    output logic                run_last,
    output logic                vector_end
);
    import fpd_pkg::*;

    logic                valid_reg;
    logic [OUT_BITS-1:0] value_reg;
    logic [IDX_BITS-1:0] index_reg;
    logic                last_reg;
    logic                vend_reg;
    logic [IDX_BITS-1:0] pos_reg;
    logic [IDX_BITS-1:0] pos_cur;

    assign pos_cur = emit.clear ? '0 : pos_reg;
    assign free    = !valid_reg || !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            pos_reg   <= '0;
        end
        else
        begin
            if (emit.load)
            begin
                valid_reg <= 1'b1;
                pos_reg   <= (pos_cur >= VEC_LAST) ? '0 : pos_cur + 1'b1;
            end
            else
            begin
                if (!out_stall)
                begin
                    valid_reg <= 1'b0;
                end
                pos_reg <= pos_cur;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit.load)
        begin
            value_reg <= OUT_BITS'(emit.value);
            index_reg <= pos_cur;
            last_reg  <= emit.last;
            vend_reg  <= (pos_cur == VEC_LAST);
        end
    end

    assign out_valid  = valid_reg;
    assign out_value  = value_reg;
    assign out_index  = index_reg;
    assign run_last   = last_reg;
    assign vector_end = vend_reg;

endmodule

// File: rtl/foveated_patch_downsampler_unit.sv
// Foveated patch downsampler: 16x16 window in, 112-byte foveated vector out.
// An average is read from the store through S_RD_B and loaded in S_AVG, a passed pixel in S_PASS;
// the column 3 item of a middle pair then adds its eight center pixels, each via S_BRD and S_BLD.
// Items with no result are taken at one per cycle; the input stalls while an item is being worked,
// and results wait while the output stalls.
// Reset (rst_n, asynchronous, active low) clears positions, state, prev pixel.
module foveated_patch_downsampler_unit (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] pixel,
    input  logic       window_start,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] out_value,
    output logic [6:0] out_index,
    output logic       run_last,
    output logic       vector_end
);
    import fpd_pkg::*;

    // Sequencer state and window position.
    state_t state_reg, state_next;
    col_t   row_reg, row_next;
    col_t   col_reg, col_next;
    pix_t   prev_reg, prev_next;

    // Per-item holding registers for the multi-cycle work.
    pix_t   pix_reg, pix_next;
    pix_t   prv_reg, prv_next;
    col_t   icol_reg, icol_next;
    logic   burst_reg, burst_next;
    pix_t   a_reg, a_next;
    logic [BURST_BITS-1:0] k_reg, k_next;

    fpd_mem_req_t mem_req;
    fpd_emit_t    emit;
    pix_t         rd_data;
    logic         out_free;

    // Decode of the accepted item's position.
    logic                accept;
    pix_t                pix_w;
    col_t                row_cur;
    col_t                col_cur;
    logic [COL_BITS-2:0] pair;
    logic                odd_row;
    logic                periph;
    logic                need_avg;
    logic                need_pass;
    logic                need_burst;
    logic [SUM_BITS-1:0] sum;

    assign accept  = in_valid && !in_stall;
    assign pix_w   = pix_t'(pixel);
    assign row_cur = window_start ? '0 : row_reg;
    assign col_cur = window_start ? '0 : col_reg;
    assign pair    = row_cur[COL_BITS-1:1];
    assign odd_row = row_cur[0];
    assign periph  = (pair < PAIR_MID_LO) || (pair > PAIR_MID_HI);

    assign need_burst = odd_row && !periph && (col_cur == BURST_COL);
    assign need_pass  = odd_row && !periph && (col_cur >= CENTER_LO)
                        && (col_cur < CENTER_HI);
    assign need_avg   = odd_row && (periph ? col_cur[0]
                        : ((col_cur == EDGE_COL_A) || (col_cur == EDGE_COL_B)
                           || (col_cur == EDGE_COL_C) || (col_cur == BURST_COL)));

    // The second store operand arrives in rd_data during the average state.
    assign sum = SUM_BITS'(a_reg) + SUM_BITS'(rd_data) + SUM_BITS'(prv_reg)
               + SUM_BITS'(pix_reg);

    assign in_stall = (state_reg != S_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            row_reg   <= '0;
            col_reg   <= '0;
            prev_reg  <= '0;
            burst_reg <= 1'b0;
            k_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            row_reg   <= row_next;
            col_reg   <= col_next;
            prev_reg  <= prev_next;
            burst_reg <= burst_next;
            k_reg     <= k_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pix_reg  <= pix_next;
        prv_reg  <= prv_next;
        icol_reg <= icol_next;
        a_reg    <= a_next;
    end

    always_comb
    begin
        state_next = state_reg;
        row_next   = row_reg;
        col_next   = col_reg;
        prev_next  = prev_reg;
        pix_next   = pix_reg;
        prv_next   = prv_reg;
        icol_next  = icol_reg;
        burst_next = burst_reg;
        a_next     = a_reg;
        k_next     = k_reg;
        mem_req    = '0;
        emit       = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    emit.clear = window_start;
                    pix_next   = pix_w;
                    prv_next   = prev_reg;
                    icol_next  = col_cur;
                    burst_next = need_burst;
                    prev_next  = pix_w;
                    col_next   = col_cur + 1'b1;
                    row_next   = (col_cur == LAST_COL) ? row_cur + 1'b1 : row_cur;
                    // Even rows only write the store and odd rows only read
                    // it, so a write and a read never meet on one entry.
                    mem_req.wr_en   = !odd_row;
                    mem_req.wr_addr = col_cur;
                    mem_req.wr_data = pix_w;
                    mem_req.rd_en   = need_avg;
                    mem_req.rd_addr = col_cur - 1'b1;
                    if (need_avg)
                    begin
                        state_next = S_RD_B;
                    end
                    else if (need_pass)
                    begin
                        state_next = S_PASS;
                    end
                end
            end
            S_RD_B:
            begin
                a_next          = rd_data;
                mem_req.rd_en   = 1'b1;
                mem_req.rd_addr = icol_reg;
                state_next      = S_AVG;
            end
            S_AVG:
            begin
                if (out_free)
                begin
                    emit.load  = 1'b1;
                    emit.value = sum[SUM_BITS-1:2];
                    emit.last  = !burst_reg;
                    k_next     = '0;
                    state_next = burst_reg ? S_BRD : S_IDLE;
                end
            end
            S_BRD:
            begin
                if (out_free)
                begin
                    mem_req.rd_en   = 1'b1;
                    mem_req.rd_addr = CENTER_LO + col_t'(k_reg);
                    state_next      = S_BLD;
                end
            end
            S_BLD:
            begin
                // The register is empty here: nothing was loaded since the
                // read was issued with the output free.
                emit.load  = 1'b1;
                emit.value = rd_data;
                emit.last  = (k_reg == BURST_END);
                k_next     = k_reg + 1'b1;
                state_next = (k_reg == BURST_END) ? S_IDLE : S_BRD;
            end
            S_PASS:
            begin
                if (out_free)
                begin
                    emit.load  = 1'b1;
                    emit.value = pix_reg;
                    emit.last  = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    fpd_line_store u_store (
        .clk     (clk),
        .req     (mem_req),
        .rd_data (rd_data)
    );

    fpd_out_stage u_out (
        .clk        (clk),
        .rst_n      (rst_n),
        .emit       (emit),
        .free       (out_free),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_value  (out_value),
        .out_index  (out_index),
        .run_last   (run_last),
        .vector_end (vector_end)
    );

endmodule

// File: rtl/fpd_checker.sv
// Port-level assertions for the foveated patch downsampler, and their bind.
// Sees only the top level's ports; uses fpd_pkg for the last vector index.
module fpd_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       in_stall,
    input logic       out_valid,
    input logic       out_stall,
    input logic [7:0] out_value,
    input logic [6:0] out_index,
    input logic       run_last,
    input logic       vector_end
);
    import fpd_pkg::*;

    // The end flag marks exactly the last byte of the vector.
    a_vend: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (vector_end == (out_index == VEC_LAST)))
        else $error("vector_end disagrees with out_index");

    a_index_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_index <= VEC_LAST))
        else $error("out_index beyond the vector");

    // A byte that is not the last of its item leaves the input closed.
    a_burst_holds_input: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !run_last) |-> in_stall)
        else $error("input open while an item still has results to give");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=>
        (out_valid && $stable(out_value) && $stable(out_index) && $stable(run_last)))
        else $error("stalled result changed");

endmodule

bind foveated_patch_downsampler_unit fpd_checker u_fpd_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_stall   (in_stall),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_value  (out_value),
    .out_index  (out_index),
    .run_last   (run_last),
    .vector_end (vector_end)
);

// File: sim/tb_top.sv
`timescale 1ns / 100ps
// Testbench for foveated_patch_downsampler_unit: streams 16x16 pixel windows and checks
// every byte of the foveated vector against a predictor kept in step with accepted pixels.
// Depends on rtl/fpd_pkg.sv and rtl/foveated_patch_downsampler_unit.sv.

typedef struct packed {
    logic [7:0] value;
    logic [6:0] index;
    logic       run_last;
    logic       vector_end;
} vec_byte_t;

// Tracks the window position and the line store, and holds the vector bytes that
// the accepted pixels have made due but that have not yet come out of the block.
class fovea_predictor;
    fpd_pkg::pix_t line_store [16];
    fpd_pkg::pix_t prev_pix;
    logic [3:0]    row_pos;
    fpd_pkg::col_t col_pos;
    logic [6:0]    out_pos;
    vec_byte_t     expected_bytes [$];
    int            errors;

    function new();
        foreach (line_store[k])
            line_store[k] = '0;
        prev_pix = '0;
        row_pos  = '0;
        col_pos  = '0;
        out_pos  = '0;
        errors   = 0;
    endfunction

    function int pending();
        return expected_bytes.size();
    endfunction

    function void queue_byte(fpd_pkg::pix_t v, logic is_last);
        vec_byte_t b;
        b.value      = v;
        b.index      = out_pos;
        b.run_last   = is_last;
        b.vector_end = (out_pos == fpd_pkg::VEC_LAST);
        expected_bytes = {expected_bytes, b};
        out_pos = (out_pos == fpd_pkg::VEC_LAST) ? 7'd0 : out_pos + 7'd1;
    endfunction

    // 2x2 mean of the stored upper pair and the held/current lower pair, truncated.
    function fpd_pkg::pix_t quad_mean(fpd_pkg::col_t c, fpd_pkg::pix_t p);
        logic [9:0] sum;
        sum = 10'(line_store[fpd_pkg::col_t'(c - 4'd1)]) + 10'(line_store[c])
            + 10'(prev_pix) + 10'(p);
        return sum[9:2];
    endfunction

    function void note_pixel(fpd_pkg::pix_t p, logic ws);
        fpd_pkg::pix_t run [$];
        fpd_pkg::col_t c;
        logic [2:0]    pair;
        if (ws)
        begin
            row_pos = '0;
            col_pos = '0;
            out_pos = '0;
        end
        c    = col_pos;
        pair = row_pos[3:1];
        if (!row_pos[0])
            line_store[c] = p;
        else if (pair < fpd_pkg::PAIR_MID_LO || pair > fpd_pkg::PAIR_MID_HI)
        begin
            if (c[0])
                run = {run, quad_mean(c, p)};
        end
        else if (c == fpd_pkg::EDGE_COL_A || c == fpd_pkg::EDGE_COL_B
                 || c == fpd_pkg::EDGE_COL_C)
            run = {run, quad_mean(c, p)};
        else if (c == fpd_pkg::BURST_COL)
        begin
            run = {run, quad_mean(c, p)};
            for (int k = fpd_pkg::CENTER_LO; k < fpd_pkg::CENTER_HI; k++)
                run = {run, line_store[k]};
        end
        else if (c >= fpd_pkg::CENTER_LO && c < fpd_pkg::CENTER_HI)
            run = {run, p};
        foreach (run[i])
            queue_byte(run[i], i == run.size() - 1);
        prev_pix = p;
        col_pos  = c + 4'd1;
        if (col_pos == '0)
            row_pos = row_pos + 4'd1;
    endfunction

    function void compare_field(string name, int want, int got);
        if (want != got)
        begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            errors++;
        end
    endfunction

    function void check_byte(vec_byte_t got);
        vec_byte_t want;
        if (expected_bytes.size() == 0)
        begin
            $display("%0t: unexpected byte, expected none, actual value %0d index %0d",
                     $time, got.value, got.index);
            errors++;
            return;
        end
        want = expected_bytes.pop_front();
        compare_field("out_value", want.value, got.value);
        compare_field("out_index", want.index, got.index);
        compare_field("run_last", want.run_last, got.run_last);
        compare_field("vector_end", want.vector_end, got.vector_end);
    endfunction
endclass

module tb_top;
    import fpd_pkg::*;

    // How a window's pixel values are chosen. Saturated windows drive every
    // 2x2 sum to its maximum, so a lost carry in the averager shows up.
    typedef enum {
        FILL_MIXED,
        FILL_SATURATED
    } fill_style_t;

    logic       clk;
    logic       rst_n;
    logic       in_valid;
    logic       in_stall;
    logic [7:0] pixel;
    logic       window_start;
    logic       out_valid;
    logic       out_stall;
    logic [7:0] out_value;
    logic [6:0] out_index;
    logic       run_last;
    logic       vector_end;

    // While quiet is set, the byte sink never stalls and the pixel source adds no random gaps before a pixel.
    logic quiet;

    fovea_predictor model;

    foveated_patch_downsampler_unit dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .pixel        (pixel),
        .window_start (window_start),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .out_value    (out_value),
        .out_index    (out_index),
        .run_last     (run_last),
        .vector_end   (vector_end)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Both handshakes are observed at the rising edge, where inputs driven at
    // the previous falling edge are stable. A byte that leaves the block at
    // this edge can never come from a pixel taken at the same edge, so the
    // order of the two calls does not matter.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && !out_stall)
                model.check_byte({out_value, out_index, run_last, vector_end});
            if (in_valid && !in_stall)
                model.note_pixel(pixel, window_start);
        end
    end

    // The byte sink stalls in about one cycle of ten, except in quiet stretches
    // and during reset.
    always @(negedge clk)
    begin
        out_stall <= rst_n && !quiet && ($urandom_range(99) < 10);
    end

    initial
    begin
        #2000000;
        $display("foveated_patch_downsampler_unit verification failed");
        $finish;
    end

    function automatic pix_t pick_pixel(fill_style_t style);
        int roll;
        if (style == FILL_SATURATED)
            return 8'hFF;
        roll = $urandom_range(19);
        if (roll < 3)
            return 8'hFF;
        if (roll < 5)
            return 8'h00;
        return pix_t'($urandom_range(255));
    endfunction

    // Called at a falling edge; returns at the falling edge after the pixel is
    // taken. Valid stays high between back-to-back pixels, and a random idle
    // gap is only inserted before a pixel is offered, never while it waits.
    task automatic send_pixel(input pix_t p, input logic ws);
        while (!quiet && $urandom_range(99) < 10)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid     <= 1'b1;
        pixel        <= p;
        window_start <= ws;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        @(negedge clk);
    endtask

    // Holds the source off until every predicted byte has come out.
    task automatic drain();
        in_valid <= 1'b0;
        while (model.pending() != 0)
            @(negedge clk);
    endtask

    // Streams count pixels; the first carries the window marker if mark is set.
    // Now and then the source stops mid-window until the block has caught up,
    // so pauses land on every phase of the row pair.
    task automatic run_window(input int count, input logic mark, input fill_style_t style);
        for (int i = 0; i < count; i++)
        begin
            if ($urandom_range(199) == 0)
                drain();
            send_pixel(pick_pixel(style), mark && (i == 0));
        end
    endtask

    initial
    begin
        in_valid     = 1'b0;
        pixel        = '0;
        window_start = 1'b0;
        quiet        = 1'b0;
        rst_n        = 1'b0;
        model        = new();
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed opening: pixel extremes and alternating bit patterns on row 0,
        // a window restart in the middle of the row, and a second restart right
        // after the first one, while the window position is one pixel past the origin.
        send_pixel(8'hFF, 1'b1);
        send_pixel(8'h00, 1'b0);
        send_pixel(8'hFF, 1'b0);
        send_pixel(8'hAA, 1'b0);
        send_pixel(8'h55, 1'b0);
        send_pixel(8'h01, 1'b0);
        send_pixel(8'h80, 1'b0);
        send_pixel(8'h7F, 1'b0);
        send_pixel(8'hFE, 1'b1);
        send_pixel(8'h00, 1'b1);
        send_pixel(8'hFF, 1'b0);
        drain();

        // Rows 0 to 5 of a new window: both upper peripheral row pairs and the
        // first middle pair with its center burst.
        run_window(96, 1'b1, FILL_MIXED);

        // Rows 6 to 8 follow with no marker. They are saturated and cover the
        // second middle pair, with quiet set for the whole stretch.
        quiet = 1'b1;
        run_window(48, 1'b0, FILL_SATURATED);
        quiet = 1'b0;
        drain();

        // A broken window: its marker abandons the vector left part-way above.
        run_window($urandom_range(16, 40), 1'b1, FILL_MIXED);

        drain();
        repeat (40) @(negedge clk);
        if (model.errors == 0)
            $display("foveated_patch_downsampler_unit verification clean");
        else
            $display("foveated_patch_downsampler_unit verification failed");
        $finish;
    end
endmodule
